// ===== rtl/ttacsr_pkg.sv =====
// Shared types, codes and helper functions of the term-to-atom CSR builder.
package ttacsr_pkg;

  localparam int unsigned AtomW    = 10;
  localparam int unsigned QueryW   = 13;
  localparam int unsigned ValueW   = 14;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned MaxArity = 5;
  localparam int unsigned TermW    = MaxArity * AtomW + 2;

  localparam logic [2:0] ReqLoad    = 3'd0;
  localparam logic [2:0] ReqBuild   = 3'd1;
  localparam logic [2:0] ReqRdBound = 3'd2;
  localparam logic [2:0] ReqRdList  = 3'd3;
  localparam logic [2:0] ReqClear   = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [1:0] StPhase = 2'd3;

  localparam logic [2:0] KindBond  = 3'd0;
  localparam logic [2:0] KindAngle = 3'd1;
  localparam logic [2:0] KindDihed = 3'd2;
  localparam logic [2:0] KindUb    = 3'd3;
  localparam logic [2:0] KindImpr  = 3'd4;
  localparam logic [2:0] KindCmap  = 3'd5;
  localparam logic [2:0] KindVsite = 3'd6;

  typedef logic [MaxArity-1:0][AtomW-1:0] atom_vec_t;

  typedef enum logic [4:0] {
    S_SWEEP_RST, S_IDLE, S_DISPATCH, S_CLEAR, S_LD_ST, S_LD_RD, S_LD_WR,
    S_K_START, S_PF_RD, S_PF_WR, S_T_CHK, S_T_RD, S_S_RD, S_S_CAP, S_A_WR,
    S_B_RD, S_B_WR, S_T_NEXT, S_RW_START, S_RW_RD, S_RW_WR, S_RW_Z, S_K_NEXT,
    S_RB_RD, S_RL_RD, S_RL_CHK, S_RL_ARD, S_RES
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAP, OP_CLR, OP_LD_ST, OP_AT_RD, OP_AT_WR, OP_K_START, OP_PF_RD,
    OP_PF_WR, OP_T_RD, OP_S_CAP, OP_A_WR, OP_T_NEXT, OP_RW_START, OP_RW_RD,
    OP_RW_WR, OP_RW_Z, OP_K_NEXT, OP_RB_RD, OP_RL_RD, OP_RL_ARD, OP_RES
  } dp_op_e;

  typedef enum logic [1:0] {RES_ZERO, RES_BOUND, RES_AFF} res_sel_e;

  typedef struct packed {
    dp_op_e     op;
    logic       bld;
    logic [1:0] res_st;
    res_sel_e   res_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       built;
    logic [1:0] ld_code;
    logic [1:0] rb_code;
    logic [1:0] rl_pre;
    logic [1:0] rl_code;
    logic       i_last;
    logic       pf_last;
    logic       t_done;
    logic       rw_last;
    logic       k_last;
    logic       sweep_last;
    logic       out_free;
  } stat_t;

  function automatic logic [2:0] touched_n(logic [2:0] kind, logic [1:0] fr);
    case (kind)
      KindBond, KindUb:    return 3'd2;
      KindAngle:           return 3'd3;
      KindDihed, KindImpr: return 3'd4;
      KindCmap:            return 3'd5;
      KindVsite:           return 3'd2 + 3'(fr[0]) + 3'(fr[1]);
      default:             return 3'd2;
    endcase
  endfunction

  function automatic logic [AtomW-1:0] touched_at(logic [2:0] kind, atom_vec_t vec,
                                                  logic [1:0] fr, logic [2:0] i);
    if (kind == KindVsite && i == 3'd2 && !fr[0]) begin
      return vec[3];
    end
    return vec[i];
  endfunction

endpackage

// ===== rtl/ttacsr_ctrl.sv =====
// Controller state machine: sequences loads, builds, reads and clearing sweeps.
module ttacsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttacsr_pkg::stat_t st_i,
  output ttacsr_pkg::cmd_t  cmd_o
);
  import ttacsr_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] res_st_q, res_st_d;
  res_sel_e   res_sel_q, res_sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP_RST;
      res_st_q  <= StOk;
      res_sel_q <= RES_ZERO;
    end else begin
      state_q   <= state_d;
      res_st_q  <= res_st_d;
      res_sel_q <= res_sel_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    res_st_d  = res_st_q;
    res_sel_d = res_sel_q;
    case (state_q)
      S_SWEEP_RST: if (st_i.sweep_last) state_d = S_IDLE;
      S_IDLE:      if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        res_st_d  = StOk;
        res_sel_d = RES_ZERO;
        case (st_i.req_type)
          ReqLoad: begin
            if (st_i.ld_code == StOk) state_d = S_LD_ST;
            else begin
              res_st_d = st_i.ld_code;
              state_d  = S_RES;
            end
          end
          ReqBuild: begin
            if (st_i.built) begin
              res_st_d = StPhase;
              state_d  = S_RES;
            end else state_d = S_K_START;
          end
          ReqRdBound: begin
            if (st_i.rb_code == StOk) begin
              res_sel_d = RES_BOUND;
              state_d   = S_RB_RD;
            end else begin
              res_st_d = st_i.rb_code;
              state_d  = S_RES;
            end
          end
          ReqRdList: begin
            if (st_i.rl_pre == StOk) state_d = S_RL_RD;
            else begin
              res_st_d = st_i.rl_pre;
              state_d  = S_RES;
            end
          end
          ReqClear: state_d = S_CLEAR;
          default: begin
            res_st_d = StPhase;
            state_d  = S_RES;
          end
        endcase
      end
      S_CLEAR:    if (st_i.sweep_last) state_d = S_RES;
      S_LD_ST:    state_d = S_LD_RD;
      S_LD_RD:    state_d = S_LD_WR;
      S_LD_WR:    state_d = st_i.i_last ? S_RES : S_LD_RD;
      S_K_START:  state_d = S_PF_RD;
      S_PF_RD:    state_d = S_PF_WR;
      S_PF_WR:    state_d = st_i.pf_last ? S_T_CHK : S_PF_RD;
      S_T_CHK:    state_d = st_i.t_done ? S_RW_START : S_T_RD;
      S_T_RD:     state_d = S_S_RD;
      S_S_RD:     state_d = S_S_CAP;
      S_S_CAP:    state_d = st_i.i_last ? S_A_WR : S_S_RD;
      S_A_WR:     if (st_i.i_last) state_d = S_B_RD;
      S_B_RD:     state_d = S_B_WR;
      S_B_WR:     state_d = st_i.i_last ? S_T_NEXT : S_B_RD;
      S_T_NEXT:   state_d = S_T_CHK;
      S_RW_START: state_d = S_RW_RD;
      S_RW_RD:    state_d = S_RW_WR;
      S_RW_WR:    state_d = st_i.rw_last ? S_RW_Z : S_RW_RD;
      S_RW_Z:     state_d = S_K_NEXT;
      S_K_NEXT:   state_d = st_i.k_last ? S_RES : S_K_START;
      S_RB_RD:    state_d = S_RES;
      S_RL_RD:    state_d = S_RL_CHK;
      S_RL_CHK: begin
        if (st_i.rl_code == StOk) begin
          res_sel_d = RES_AFF;
          state_d   = S_RL_ARD;
        end else begin
          res_st_d = st_i.rl_code;
          state_d  = S_RES;
        end
      end
      S_RL_ARD:   state_d = S_RES;
      S_RES:      if (st_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.bld     = 1'b0;
    cmd_o.res_st  = res_st_q;
    cmd_o.res_sel = res_sel_q;
    case (state_q)
      S_SWEEP_RST, S_CLEAR: cmd_o.op = OP_CLR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_CAP;
      end
      S_LD_ST:    cmd_o.op = OP_LD_ST;
      S_LD_RD:    cmd_o.op = OP_AT_RD;
      S_LD_WR:    cmd_o.op = OP_AT_WR;
      S_K_START:  begin cmd_o.op = OP_K_START;  cmd_o.bld = 1'b1; end
      S_PF_RD:    begin cmd_o.op = OP_PF_RD;    cmd_o.bld = 1'b1; end
      S_PF_WR:    begin cmd_o.op = OP_PF_WR;    cmd_o.bld = 1'b1; end
      S_T_CHK:    cmd_o.bld = 1'b1;
      S_T_RD:     begin cmd_o.op = OP_T_RD;     cmd_o.bld = 1'b1; end
      S_S_RD:     begin cmd_o.op = OP_AT_RD;    cmd_o.bld = 1'b1; end
      S_S_CAP:    begin cmd_o.op = OP_S_CAP;    cmd_o.bld = 1'b1; end
      S_A_WR:     begin cmd_o.op = OP_A_WR;     cmd_o.bld = 1'b1; end
      S_B_RD:     begin cmd_o.op = OP_AT_RD;    cmd_o.bld = 1'b1; end
      S_B_WR:     begin cmd_o.op = OP_AT_WR;    cmd_o.bld = 1'b1; end
      S_T_NEXT:   begin cmd_o.op = OP_T_NEXT;   cmd_o.bld = 1'b1; end
      S_RW_START: begin cmd_o.op = OP_RW_START; cmd_o.bld = 1'b1; end
      S_RW_RD:    begin cmd_o.op = OP_RW_RD;    cmd_o.bld = 1'b1; end
      S_RW_WR:    begin cmd_o.op = OP_RW_WR;    cmd_o.bld = 1'b1; end
      S_RW_Z:     begin cmd_o.op = OP_RW_Z;     cmd_o.bld = 1'b1; end
      S_K_NEXT:   begin cmd_o.op = OP_K_NEXT;   cmd_o.bld = 1'b1; end
      S_RB_RD:    cmd_o.op = OP_RB_RD;
      S_RL_RD:    cmd_o.op = OP_RL_RD;
      S_RL_ARD:   cmd_o.op = OP_RL_ARD;
      S_RES:      if (st_i.out_free) cmd_o.op = OP_RES;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/ttacsr_dp.sv =====
// Datapath: term, bound and list memories, counters and the result register.
module ttacsr_dp #(
  parameter int unsigned ATOM_LIMIT = 1024,
  parameter int unsigned MAX_TERMS  = 1024,
  parameter int unsigned LIST_DEPTH = 8192,
  parameter int unsigned NUM_KINDS  = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ttacsr_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic [2:0]                        in_type_i,
  input  logic [2:0]                        in_kind_i,
  input  ttacsr_pkg::atom_vec_t             in_atoms_i,
  input  logic [1:0]                        in_frame_i,
  input  logic [ttacsr_pkg::QueryW-1:0]     in_query_i,
  input  ttacsr_pkg::cmd_t                  cmd_i,
  input  logic                              out_ready_i,
  output ttacsr_pkg::stat_t                 st_o,
  output logic                              out_valid_o,
  output logic [1:0]                        out_status_o,
  output logic [ttacsr_pkg::ValueW-1:0]     out_value_o
);
  import ttacsr_pkg::*;

  localparam int unsigned BDepth = ATOM_LIMIT + 1;
  localparam int unsigned BTot   = NUM_KINDS * BDepth;
  localparam int unsigned ATot   = NUM_KINDS * LIST_DEPTH;
  localparam int unsigned TTot   = NUM_KINDS * MAX_TERMS;
  localparam int unsigned BAW    = $clog2(BTot);
  localparam int unsigned AAW    = $clog2(ATot);
  localparam int unsigned TAW    = (TTot > 1) ? $clog2(TTot) : 1;
  localparam int unsigned KW     = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int unsigned A1W    = $clog2(BDepth);
  localparam int unsigned CNW    = $clog2(MAX_TERMS + 1);
  localparam int unsigned TNW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned BW     = $clog2(MaxArity * MAX_TERMS + 1);
  localparam int unsigned SweepN = (BTot > ATot) ? BTot : ATot;
  localparam int unsigned SW     = $clog2(SweepN + 1);
  localparam int unsigned AcRst  = (ATOM_LIMIT < 1024) ? ATOM_LIMIT : 1024;

  function automatic logic [BAW-1:0] baddr(logic [KW-1:0] k, logic [A1W-1:0] a);
    return BAW'(k) * BAW'(BDepth) + BAW'(a);
  endfunction

  function automatic logic [AAW-1:0] aaddr(logic [KW-1:0] k, logic [AAW-1:0] s);
    return AAW'(k) * AAW'(LIST_DEPTH) + s;
  endfunction

  function automatic logic [TAW-1:0] taddr(logic [KW-1:0] k, logic [TNW-1:0] t);
    return TAW'(k) * TAW'(MAX_TERMS) + TAW'(t);
  endfunction

  logic [BW-1:0]    bmem [BTot];
  logic [TNW-1:0]   amem [ATot];
  logic [TermW-1:0] tmem [TTot];
  logic [BW-1:0]    brd_q;
  logic [TNW-1:0]   ard_q;
  logic [TermW-1:0] trd_q;

  logic [2:0]        rq_type_q, rq_kind_q;
  atom_vec_t         rq_at_q;
  logic [1:0]        rq_fr_q;
  logic [QueryW-1:0] rq_query_q;
  logic [BW-1:0]     slot_q [MaxArity];
  logic [BW-1:0]     run_q;
  logic [1:0]        out_status_q;
  logic [ValueW-1:0] out_value_q;

  logic [CfgW-1:0] atoms_used_q;
  logic [CNW-1:0]  counts_q [NUM_KINDS];
  logic            built_q, out_valid_q;
  logic [KW-1:0]   k_q;
  logic [CNW-1:0]  t_q;
  logic [SW-1:0]   idx_q;
  logic [2:0]      i_q;

  logic [KW-1:0]    rk, ks;
  logic [2:0]       kind_sel, n_sel, ld_n;
  atom_vec_t        vec_sel;
  logic [1:0]       fr_sel;
  logic [AtomW-1:0] cur_at;
  logic [A1W-1:0]   idx_at;
  logic             i_last, kind_ok, atoms_ok, any_loaded;
  logic [CNW-1:0]   cnt_sel;
  logic [CfgW-1:0]  cfg_v;

  logic             b_we, b_re, a_we, a_re, t_we, t_re;
  logic [BAW-1:0]   b_waddr, b_raddr;
  logic [BW-1:0]    b_wdata;
  logic [AAW-1:0]   a_waddr, a_raddr;
  logic [TNW-1:0]   a_wdata;
  logic [TAW-1:0]   t_waddr, t_raddr;

  assign rk       = rq_kind_q[KW-1:0];
  assign ks       = cmd_i.bld ? k_q : rk;
  assign kind_sel = cmd_i.bld ? 3'(k_q) : rq_kind_q;
  assign vec_sel  = cmd_i.bld ? trd_q[MaxArity*AtomW-1:0] : rq_at_q;
  assign fr_sel   = cmd_i.bld ? trd_q[TermW-1:TermW-2] : rq_fr_q;
  assign n_sel    = touched_n(kind_sel, fr_sel);
  assign cur_at   = touched_at(kind_sel, vec_sel, fr_sel, i_q);
  assign i_last   = (i_q == n_sel - 3'd1);
  assign idx_at   = idx_q[A1W-1:0];
  assign kind_ok  = 32'(rq_kind_q) < NUM_KINDS;
  assign cnt_sel  = kind_ok ? counts_q[rk] : '0;
  assign ld_n     = touched_n(rq_kind_q, rq_fr_q);

  always_comb begin
    atoms_ok = 1'b1;
    for (int j = 0; j < MaxArity; j++) begin
      if (3'(j) < ld_n &&
          {1'b0, touched_at(rq_kind_q, rq_at_q, rq_fr_q, 3'(j))} >= atoms_used_q) begin
        atoms_ok = 1'b0;
      end
    end
    any_loaded = 1'b0;
    for (int j = 0; j < NUM_KINDS; j++) begin
      if (counts_q[j] != '0) any_loaded = 1'b1;
    end
    cfg_v = cfg_wdata_i;
    if (cfg_v == '0) cfg_v = CfgW'(1);
    if (32'(cfg_v) > ATOM_LIMIT) cfg_v = CfgW'(ATOM_LIMIT);
  end

  always_comb begin
    st_o.req_type = rq_type_q;
    st_o.built    = built_q;
    if (built_q) st_o.ld_code = StPhase;
    else if (!kind_ok) st_o.ld_code = StRange;
    else if (32'(cnt_sel) >= MAX_TERMS) st_o.ld_code = StFull;
    else if (!atoms_ok) st_o.ld_code = StRange;
    else st_o.ld_code = StOk;
    if (!built_q) st_o.rb_code = StPhase;
    else if (!kind_ok || 32'(rq_query_q) > 32'(atoms_used_q)) st_o.rb_code = StRange;
    else st_o.rb_code = StOk;
    if (!built_q) st_o.rl_pre = StPhase;
    else if (!kind_ok || 32'(rq_query_q) >= LIST_DEPTH) st_o.rl_pre = StRange;
    else st_o.rl_pre = StOk;
    st_o.rl_code    = (32'(rq_query_q) >= 32'(brd_q)) ? StRange : StOk;
    st_o.i_last     = i_last;
    st_o.pf_last    = (idx_q == SW'(atoms_used_q));
    st_o.t_done     = (t_q == counts_q[k_q]);
    st_o.rw_last    = (idx_q == SW'(1));
    st_o.k_last     = (32'(k_q) == NUM_KINDS - 1);
    st_o.sweep_last = (idx_q == SW'(SweepN - 1));
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    b_we    = 1'b0;
    b_re    = 1'b0;
    b_waddr = baddr(ks, A1W'(cur_at));
    b_raddr = b_waddr;
    b_wdata = '0;
    a_we    = 1'b0;
    a_re    = 1'b0;
    a_waddr = aaddr(k_q, AAW'(slot_q[i_q]));
    a_wdata = t_q[TNW-1:0];
    a_raddr = aaddr(rk, AAW'(rq_query_q));
    t_we    = 1'b0;
    t_re    = 1'b0;
    t_waddr = taddr(rk, cnt_sel[TNW-1:0]);
    t_raddr = taddr(k_q, t_q[TNW-1:0]);
    case (cmd_i.op)
      OP_CLR: begin
        b_we    = 32'(idx_q) < BTot;
        b_waddr = BAW'(idx_q);
        a_we    = 32'(idx_q) < ATot;
        a_waddr = AAW'(idx_q);
        a_wdata = '0;
      end
      OP_LD_ST: t_we = 1'b1;
      OP_AT_RD: b_re = 1'b1;
      OP_AT_WR: begin
        b_we    = 1'b1;
        b_wdata = brd_q + BW'(1);
      end
      OP_PF_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(k_q, idx_at);
      end
      OP_PF_WR: begin
        b_we    = 1'b1;
        b_waddr = baddr(k_q, idx_at);
        b_wdata = run_q;
      end
      OP_T_RD:  t_re = 1'b1;
      OP_A_WR:  a_we = 32'(slot_q[i_q]) < LIST_DEPTH;
      OP_RW_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(k_q, idx_at - A1W'(1));
      end
      OP_RW_WR: begin
        b_we    = 1'b1;
        b_waddr = baddr(k_q, idx_at);
        b_wdata = brd_q;
      end
      OP_RW_Z: begin
        b_we    = 1'b1;
        b_waddr = baddr(k_q, '0);
      end
      OP_RB_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(rk, A1W'(rq_query_q));
      end
      OP_RL_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(rk, A1W'(atoms_used_q));
      end
      OP_RL_ARD: a_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    if (b_re) brd_q <= bmem[b_raddr];
    if (a_we) amem[a_waddr] <= a_wdata;
    if (a_re) ard_q <= amem[a_raddr];
    if (t_we) tmem[t_waddr] <= {rq_fr_q, rq_at_q};
    if (t_re) trd_q <= tmem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAP: begin
        rq_type_q  <= in_type_i;
        rq_kind_q  <= in_kind_i;
        rq_at_q    <= in_atoms_i;
        rq_fr_q    <= in_frame_i;
        rq_query_q <= in_query_i;
      end
      OP_K_START: run_q <= '0;
      OP_PF_WR:   run_q <= run_q + brd_q;
      OP_S_CAP:   slot_q[i_q] <= brd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RES) begin
      out_status_q <= cmd_i.res_st;
      case (cmd_i.res_sel)
        RES_BOUND: out_value_q <= ValueW'(brd_q);
        RES_AFF:   out_value_q <= ValueW'(ard_q);
        default:   out_value_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atoms_used_q <= CfgW'(AcRst);
      for (int j = 0; j < NUM_KINDS; j++) counts_q[j] <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      t_q         <= '0;
      idx_q       <= '0;
      i_q         <= '0;
    end else begin
      if (cfg_we_i && !built_q && !any_loaded) atoms_used_q <= cfg_v;
      if (cmd_i.op == OP_RES) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_CAP: begin
          i_q   <= '0;
          idx_q <= '0;
          k_q   <= '0;
        end
        OP_CLR: begin
          idx_q   <= idx_q + SW'(1);
          built_q <= 1'b0;
          for (int j = 0; j < NUM_KINDS; j++) counts_q[j] <= '0;
        end
        OP_LD_ST: counts_q[rk] <= counts_q[rk] + CNW'(1);
        OP_AT_WR, OP_S_CAP, OP_A_WR: i_q <= i_last ? 3'd0 : i_q + 3'd1;
        OP_K_START: begin
          idx_q <= '0;
          t_q   <= '0;
          i_q   <= '0;
        end
        OP_PF_WR:    idx_q <= idx_q + SW'(1);
        OP_T_NEXT:   t_q <= t_q + CNW'(1);
        OP_RW_START: idx_q <= SW'(atoms_used_q);
        OP_RW_WR:    idx_q <= idx_q - SW'(1);
        OP_K_NEXT: begin
          if (32'(k_q) == NUM_KINDS - 1) built_q <= 1'b1;
          else k_q <= k_q + KW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;

  a_cfg_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (built_q || any_loaded) |=> $stable(atoms_used_q))
    else $error("atom count changed while terms are held");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    atoms_used_q != '0 && 32'(atoms_used_q) <= ATOM_LIMIT)
    else $error("atom count out of range");

  a_built_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (built_q && cmd_i.op != OP_CLR) |=> built_q)
    else $error("built flag dropped without a clear");

endmodule

// ===== rtl/term_to_atom_csr_builder.sv =====
// Top level of the term-to-atom CSR builder: stream ports, controller and datapath.
//
// One request enters on the slave stream; exactly one response leaves on the
// master stream. tuser carries the request type and term kind, tdata the atoms,
// the virtual-site frame bits and the query index. The response carries a status
// code and the bound or term number that was read.
// Requests are handled one at a time. A load writes the term into the term memory,
// then does one read-modify-write of the bound memory per touched atom. A read bound
// reads the bound memory once; a read list entry reads the bound at the atom count,
// checks the query index against it and then reads the list memory. A build walks
// each kind: a prefix sum over its bounds, a scatter of each loaded term into the
// list memory, a rewind of the bounds, then on to the next kind. A clear sweeps the
// bound and list memories one entry a cycle, over as many entries as the larger of
// the two holds. The same sweep runs after reset, with s_axis_tready low.
// The response sits in an output register; a new request is taken while it waits,
// and the next response holds back until the receiver takes the old one.
// The atom count register is written from cfg_we_i/cfg_wdata_i; it is ignored
// while terms are held or the index is built.
module term_to_atom_csr_builder #(
  parameter int unsigned ATOM_LIMIT = 1024,
  parameter int unsigned MAX_TERMS  = 1024,
  parameter int unsigned LIST_DEPTH = 8192,
  parameter int unsigned NUM_KINDS  = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // atom_a, atom_b, atom_c, atom_d, atom_e, frame_present, query_index, zero pad
  input  logic [71:0] s_axis_tdata,
  // req_type, kind
  input  logic [5:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, read_value
  output logic [15:0] m_axis_tdata
);
  import ttacsr_pkg::*;

  cmd_t              cmd;
  stat_t             st;
  atom_vec_t         atoms;
  logic [1:0]        out_status;
  logic [ValueW-1:0] out_value;

  assign atoms = s_axis_tdata[MaxArity*AtomW-1:0];

  ttacsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ttacsr_dp #(
    .ATOM_LIMIT (ATOM_LIMIT),
    .MAX_TERMS  (MAX_TERMS),
    .LIST_DEPTH (LIST_DEPTH),
    .NUM_KINDS  (NUM_KINDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_type_i    (s_axis_tuser[2:0]),
    .in_kind_i    (s_axis_tuser[5:3]),
    .in_atoms_i   (atoms),
    .in_frame_i   (s_axis_tdata[51:50]),
    .in_query_i   (s_axis_tdata[64:52]),
    .cmd_i        (cmd),
    .out_ready_i  (m_axis_tready),
    .st_o         (st),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_value_o  (out_value)
  );

  assign m_axis_tdata = {out_value, out_status};

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the term-to-atom CSR builder: directed table, then random phases.
module testbench;
  import ttacsr_pkg::*;

  localparam int unsigned NumKinds  = 7;
  localparam int unsigned AtomLimit = 1024;
  localparam int unsigned MaxTerms  = 1024;
  localparam int unsigned ListDepth = 8192;
  localparam int unsigned CycleLimit = 4000000;
  localparam logic [2:0] KindBad = 3'd7;

  typedef struct packed {
    logic [2:0]       req;
    logic [2:0]       kind;
    logic [4:0][9:0]  at;
    logic [1:0]       fr;
    logic [12:0]      q;
  } term_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] value;
  } term_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic [5:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  term_to_atom_csr_builder i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned stall_left = 0;
  term_resp_t  pending_resp[$];

  // index model
  logic [9:0]  store_atoms [NumKinds][MaxTerms][5];
  logic [1:0]  store_fr    [NumKinds][MaxTerms];
  int unsigned term_cnt    [NumKinds];
  int unsigned bounds      [NumKinds][AtomLimit+1];
  int unsigned affectors   [NumKinds][ListDepth];
  bit          is_built;
  int unsigned n_atoms;

  function automatic bit quiet_stretch();
    return ((cycles >> 11) % 4) == 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else if (quiet_stretch() || r >= 20) begin
      m_ready <= 1'b1;
    end else begin
      stall_left <= (r < 2) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      m_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    term_resp_t got, want;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got.status = m_axis_tdata[1:0];
      got.value  = m_axis_tdata[15:2];
      if (pending_resp.size() == 0) begin
        $error("response with nothing pending: status %0d value %0d", got.status, got.value);
        errors++;
      end else begin
        want = pending_resp.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
        if (got.value !== want.value) begin
          $error("read_value: expected %0d, actual %0d", want.value, got.value);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned touched_list(logic [2:0] kind, logic [4:0][9:0] at,
                                               logic [1:0] fr, output logic [4:0][9:0] lst);
    int unsigned n;
    lst = '0;
    n = 0;
    case (kind)
      KindBond, KindUb: n = 2;
      KindAngle:        n = 3;
      KindDihed, KindImpr: n = 4;
      KindCmap:         n = 5;
      default:          n = 2;
    endcase
    for (int i = 0; i < 5; i++) lst[i] = at[i];
    if (kind == KindVsite) begin
      if (fr[0]) begin
        lst[n] = at[2];
        n++;
      end
      if (fr[1]) begin
        lst[n] = at[3];
        n++;
      end
    end
    return n;
  endfunction

  function automatic void clear_index();
    for (int k = 0; k < NumKinds; k++) begin
      term_cnt[k] = 0;
      for (int a = 0; a <= AtomLimit; a++) bounds[k][a] = 0;
      for (int s = 0; s < ListDepth; s++) affectors[k][s] = 0;
    end
    is_built = 0;
  endfunction

  function automatic void build_kind(int k);
    int unsigned run, c, n;
    int unsigned slot [5];
    logic [4:0][9:0] at, lst;
    run = 0;
    for (int a = 0; a <= n_atoms; a++) begin
      c = bounds[k][a];
      bounds[k][a] = run;
      run += c;
    end
    for (int t = 0; t < term_cnt[k]; t++) begin
      for (int i = 0; i < 5; i++) at[i] = store_atoms[k][t][i];
      n = touched_list(3'(k), at, store_fr[k][t], lst);
      for (int i = 0; i < n; i++) slot[i] = bounds[k][lst[i]];
      for (int i = 0; i < n; i++) if (slot[i] < ListDepth) affectors[k][slot[i]] = t;
      for (int i = 0; i < n; i++) bounds[k][lst[i]] += 1;
    end
    for (int a = n_atoms; a > 0; a--) bounds[k][a] = bounds[k][a-1];
    bounds[k][0] = 0;
  endfunction

  function automatic void write_atom_count(logic [10:0] v);
    bit loaded;
    loaded = 0;
    for (int k = 0; k < NumKinds; k++) if (term_cnt[k] != 0) loaded = 1;
    if (is_built || loaded) return;
    n_atoms = (v < 1) ? 1 : (v > AtomLimit) ? AtomLimit : v;
  endfunction

  function automatic term_resp_t apply_request(term_req_t r);
    term_resp_t res;
    logic [4:0][9:0] lst;
    int unsigned n, k;
    res = '0;
    k = r.kind;
    case (r.req)
      ReqLoad: begin
        if (is_built) res.status = StPhase;
        else if (k >= NumKinds) res.status = StRange;
        else if (term_cnt[k] >= MaxTerms) res.status = StFull;
        else begin
          n = touched_list(r.kind, r.at, r.fr, lst);
          for (int i = 0; i < n; i++) if (lst[i] >= n_atoms) res.status = StRange;
          if (res.status == StOk) begin
            for (int i = 0; i < 5; i++) store_atoms[k][term_cnt[k]][i] = r.at[i];
            store_fr[k][term_cnt[k]] = r.fr;
            term_cnt[k]++;
            for (int i = 0; i < n; i++) bounds[k][lst[i]] += 1;
          end
        end
      end
      ReqBuild: begin
        if (is_built) res.status = StPhase;
        else begin
          for (int i = 0; i < NumKinds; i++) build_kind(i);
          is_built = 1;
        end
      end
      ReqRdBound: begin
        if (!is_built) res.status = StPhase;
        else if (k >= NumKinds || r.q > n_atoms) res.status = StRange;
        else res.value = 14'(bounds[k][r.q]);
      end
      ReqRdList: begin
        if (!is_built) res.status = StPhase;
        else if (k >= NumKinds || r.q >= ListDepth || r.q >= bounds[k][n_atoms])
          res.status = StRange;
        else res.value = 14'(affectors[k][r.q]);
      end
      ReqClear: clear_index();
      default: res.status = StPhase;
    endcase
    return res;
  endfunction

  task automatic send_request(term_req_t r, bit typed, term_resp_t typed_resp);
    int unsigned gap, sel;
    term_resp_t pred;
    sel = $urandom_range(0, 99);
    gap = (quiet_stretch() || sel < 60) ? 0 : (sel < 95) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 40);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, r.q, r.fr, r.at[4], r.at[3], r.at[2], r.at[1], r.at[0]};
    s_user  <= {r.kind, r.req};
    do @(posedge clk); while (!s_axis_tready);
    pred = apply_request(r);
    pending_resp.push_back(typed ? typed_resp : pred);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [10:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    write_atom_count(v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic term_req_t mk(logic [2:0] req, logic [2:0] kind, logic [9:0] a,
                                   logic [9:0] b, logic [9:0] c, logic [9:0] d,
                                   logic [9:0] e, logic [1:0] fr, logic [12:0] q);
    term_req_t r;
    r.req = req;
    r.kind = kind;
    r.at = {e, d, c, b, a};
    r.fr = fr;
    r.q = q;
    return r;
  endfunction

  function automatic term_req_t rand_load(bit bond_only);
    term_req_t r;
    r = mk(ReqLoad, bond_only ? KindBond : 3'($urandom_range(0, NumKinds - 1)),
           0, 0, 0, 0, 0, 2'($urandom_range(0, 3)), 13'($urandom));
    for (int i = 0; i < 5; i++) r.at[i] = 10'($urandom_range(0, n_atoms - 1));
    if ($urandom_range(0, 9) == 0) r.at[$urandom_range(1, 4)] = r.at[0];
    return r;
  endfunction

  function automatic term_req_t rand_noise();
    term_req_t r;
    logic [2:0] req_pick [7] = '{ReqLoad, ReqBuild, ReqRdBound, ReqRdList, 3'd5, 3'd6, 3'd7};
    r = term_req_t'(71'({$urandom, $urandom, $urandom}));
    r.req = req_pick[$urandom_range(0, 6)];
    return r;
  endfunction

  function automatic term_req_t rand_read();
    term_req_t r;
    int unsigned k, total;
    k = $urandom_range(0, NumKinds - 1);
    total = bounds[k][n_atoms];
    if ($urandom_range(0, 1) == 0)
      r = mk(ReqRdBound, 3'(k), 0, 0, 0, 0, 0, 0, 13'($urandom_range(0, n_atoms)));
    else
      r = mk(ReqRdList, 3'(k), 0, 0, 0, 0, 0, 0,
             (total == 0) ? 13'd0 : 13'($urandom_range(0, total - 1)));
    for (int i = 0; i < 5; i++) r.at[i] = 10'($urandom);
    r.fr = 2'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      r.q = 13'($urandom);
      r.kind = 3'($urandom);
    end
    return r;
  endfunction

  task automatic run_phase(logic [10:0] ac, int unsigned loads, int unsigned noise_pct,
                           bit bond_only);
    term_req_t r;
    cfg_write(ac);
    for (int i = 0; i < loads; i++) begin
      if (i == loads / 2) cfg_write(11'($urandom));
      r = ($urandom_range(0, 99) < noise_pct) ? rand_noise() : rand_load(bond_only);
      send_request(r, 0, '0);
    end
    send_request(mk(ReqBuild, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    for (int i = 0; i < 30; i++) send_request(rand_read(), 0, '0);
    send_request(mk(ReqClear, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
  endtask

  typedef struct packed {
    term_req_t  r;
    logic       typed;
    term_resp_t resp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add(term_req_t r, logic typed, logic [1:0] st, logic [13:0] v);
    dir_rows.push_back('{r, typed, '{st, v}});
  endfunction

  initial begin
    clear_index();
    n_atoms = AtomLimit;

    add(mk(ReqRdBound, KindBond, 0, 0, 0, 0, 0, 0, 0), 1, StPhase, 0);
    add(mk(ReqRdList, KindBond, 0, 0, 0, 0, 0, 0, 0), 1, StPhase, 0);
    add(mk(3'd5, KindBond, 0, 0, 0, 0, 0, 0, 0), 1, StPhase, 0);
    add(mk(3'd6, KindAngle, 0, 0, 0, 0, 0, 0, 0), 1, StPhase, 0);
    add(mk(3'd7, KindBad, '1, '1, '1, '1, '1, '1, '1), 1, StPhase, 0);
    add(mk(ReqLoad, KindBad, 0, 1, 2, 3, 4, 0, 0), 1, StRange, 0);
    add(mk(ReqLoad, KindBond, 0, 1023, 0, 0, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindAngle, 1023, 0, 512, 0, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindDihed, 5, 5, 5, 5, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindUb, 1, 1, 0, 0, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindImpr, 2, 3, 4, 1023, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindCmap, 1023, 1022, 1021, 1020, 1019, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindVsite, 7, 8, 1023, 1023, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindVsite, 7, 8, 9, 1023, 0, 1, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindVsite, 7, 8, 1023, 10, 0, 2, 0), 1, StOk, 0);
    add(mk(ReqLoad, KindVsite, 9, 9, 9, 9, 0, 3, 0), 1, StOk, 0);
    add(mk(ReqBuild, 0, 0, 0, 0, 0, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqBuild, 0, 0, 0, 0, 0, 0, 0, 0), 1, StPhase, 0);
    add(mk(ReqLoad, KindBond, 0, 1, 0, 0, 0, 0, 0), 1, StPhase, 0);
    add(mk(ReqRdBound, KindBond, 0, 0, 0, 0, 0, 0, 0), 1, StOk, 0);
    add(mk(ReqRdBound, KindBond, 0, 0, 0, 0, 0, 0, 1024), 1, StOk, 2);
    add(mk(ReqRdBound, KindBond, 0, 0, 0, 0, 0, 0, 1025), 1, StRange, 0);
    add(mk(ReqRdBound, KindBad, 0, 0, 0, 0, 0, 0, 0), 1, StRange, 0);
    add(mk(ReqRdBound, KindVsite, 0, 0, 0, 0, 0, 0, 9), 0, StOk, 0);
    add(mk(ReqRdList, KindDihed, 0, 0, 0, 0, 0, 0, 0), 0, StOk, 0);
    add(mk(ReqRdList, KindVsite, 0, 0, 0, 0, 0, 0, 7), 0, StOk, 0);
    add(mk(ReqRdList, KindBond, 0, 0, 0, 0, 0, 0, 8191), 1, StRange, 0);
    add(mk(ReqRdList, KindBad, 0, 0, 0, 0, 0, 0, 0), 1, StRange, 0);
    add(mk(ReqClear, 0, 0, 0, 0, 0, 0, 0, 0), 1, StOk, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);

    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].resp);

    run_phase(11'd0, 30, 15, 0);
    run_phase(11'd2047, 60, 0, 0);
    for (int p = 0; p < 4; p++) run_phase(11'($urandom_range(2, 64)), 50, 12, 0);
    run_phase(11'd1024, MaxTerms + 6, 0, 1);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
